/* hdl/artt_pkg.sv */
// Package for the ACK/RTT window tracker: payload and control structs, event codes,
// register indexes and saturation helper.
// No dependencies; compiled first.
package artt_pkg;

    localparam int SEQ_BITS  = 3;
    localparam int TIME_BITS = 24;

    typedef logic [SEQ_BITS-1:0]  t_seq;
    typedef logic [TIME_BITS-1:0] t_time;

    // event kinds
    localparam logic [2:0] KIND_SETUP  = 3'd0;
    localparam logic [2:0] KIND_SEND   = 3'd1;
    localparam logic [2:0] KIND_ACK    = 3'd2;
    localparam logic [2:0] KIND_REJECT = 3'd3;
    localparam logic [2:0] KIND_RETX   = 3'd4;

    // register indexes (paddr[2])
    localparam logic REG_MAX_WINDOW   = 1'b0;
    localparam logic REG_BASE_TIMEOUT = 1'b1;

    localparam t_seq        MAX_OUTSTANDING = 3'd7;
    localparam t_time       MAX24           = 24'hFF_FFFF;
    localparam logic [8:0]  MIN_RTO         = 9'd500;

    // radix-8 divider: 3 quotient bits per cycle
    localparam int DIV_BITS_PER_CYCLE = 3;
    localparam int DIV_CYCLES         = TIME_BITS / DIV_BITS_PER_CYCLE;

    typedef struct packed {
        logic [2:0]  kind;
        logic [2:0]  ack_number;
        logic [31:0] now_ms;
        logic [3:0]  hop_count;
    } t_evt;

    typedef struct packed {
        logic        accepted;
        logic [2:0]  sent_sequence;
        logic [2:0]  frames_acked;
        logic [2:0]  unacked_count;
        logic [2:0]  window_size;
        logic [23:0] retry_timeout_ms;
        logic        all_acked;
    } t_res;

    typedef struct packed {
        logic load;
        logic exec;
        logic meas;
        logic div_start;
        logic grow;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic need_meas;
        logic need_grow;
        logic div_done;
        logic out_free;
    } t_sts;

    function automatic t_time sat24(input logic [34:0] v);
        sat24 = (v > 35'(MAX24)) ? MAX24 : v[TIME_BITS-1:0];
    endfunction

endpackage

/* hdl/artt_if.sv */
// Valid/ready channel interfaces for the event input and the result output.
// Depends on artt_pkg.
interface artt_evt_if;
    import artt_pkg::*;
    logic valid;
    logic ready;
    t_evt data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface artt_res_if;
    import artt_pkg::*;
    logic valid;
    logic ready;
    t_res data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* hdl/artt_div.sv */
// Iterative unsigned divider, 24-bit dividend by 3-bit nonzero divisor,
// three quotient bits per cycle. Depends on artt_pkg.
module artt_div (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  artt_pkg::t_time       i_dividend,
    input  artt_pkg::t_seq        i_divisor,
    output artt_pkg::t_time       o_quotient,
    output logic                  o_done
);
    import artt_pkg::*;

    localparam int CNT_BITS = $clog2(DIV_CYCLES);

    logic                r_busy;
    logic                r_done;
    logic [CNT_BITS-1:0] r_cnt;
    t_seq                r_rem;
    t_time               r_quo;
    t_seq                r_div;

    t_seq                n_rem;
    t_time               n_quo;
    logic [SEQ_BITS:0]   trial;

    // restoring steps; remainder stays below the divisor, so it is narrow
    always_comb begin
        n_rem = r_rem;
        n_quo = r_quo;
        trial = '0;
        for (int j = 0; j < DIV_BITS_PER_CYCLE; j++) begin
            trial = {n_rem, n_quo[TIME_BITS-1]};
            n_quo = {n_quo[TIME_BITS-2:0], 1'b0};
            if (trial >= {1'b0, r_div}) begin
                n_rem    = SEQ_BITS'(trial - {1'b0, r_div});
                n_quo[0] = 1'b1;
            end else begin
                n_rem = trial[SEQ_BITS-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_BITS'(DIV_CYCLES - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_quo <= n_quo;
            r_rem <= n_rem;
        end
    end

    assign o_quotient = r_quo;
    assign o_done     = r_done;

endmodule

/* hdl/artt_ctrl.sv */
// Sequencing FSM of the tracker: steps each event through execute, optional
// measurement and window-growth divide, and result load. Depends on artt_pkg.
module artt_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_evt_valid,
    output logic            o_evt_ready,
    input  artt_pkg::t_sts  i_sts,
    output artt_pkg::t_cmd  o_cmd
);
    import artt_pkg::*;

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_EXEC     = 3'd1;
    localparam logic [2:0] S_MEAS     = 3'd2;
    localparam logic [2:0] S_DIV_GO   = 3'd3;
    localparam logic [2:0] S_DIV_WAIT = 3'd4;
    localparam logic [2:0] S_GROW     = 3'd5;
    localparam logic [2:0] S_DONE     = 3'd6;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.load = i_evt_valid;
                if (i_evt_valid) n_state = S_EXEC;
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = i_sts.need_meas ? S_MEAS : S_DONE;
            end
            S_MEAS: begin
                o_cmd.meas = 1'b1;
                n_state    = i_sts.need_grow ? S_DIV_GO : S_DONE;
            end
            S_DIV_GO: begin
                o_cmd.div_start = 1'b1;
                n_state         = S_DIV_WAIT;
            end
            S_DIV_WAIT: begin
                if (i_sts.div_done) n_state = S_GROW;
            end
            S_GROW: begin
                o_cmd.grow = 1'b1;
                n_state    = S_DONE;
            end
            S_DONE: begin
                // wait for the output register to free up
                o_cmd.out_load = i_sts.out_free;
                if (i_sts.out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_evt_ready = (r_state == S_IDLE);

endmodule

/* hdl/artt_dp.sv */
// Datapath of the tracker: window and sequence state, RTT estimator, divider
// and output register. Depends on artt_pkg and artt_div.
module artt_dp (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic [2:0]      i_max_window,
    input  logic [15:0]     i_base_timeout,
    input  artt_pkg::t_evt  i_evt,
    input  artt_pkg::t_cmd  i_cmd,
    output artt_pkg::t_sts  o_sts,
    output logic            o_res_valid,
    output artt_pkg::t_res  o_res,
    input  logic            i_res_ready
);
    import artt_pkg::*;

    t_evt        r_evt;
    t_time       r_srt;
    t_time       r_mdev;
    t_seq        r_cwnd;
    t_seq        r_outst;
    t_seq        r_send_seq;
    t_seq        r_timed_seq;
    logic [31:0] r_timed_start;
    logic        r_timing;
    logic        r_retx;
    logic        r_accepted;
    t_seq        r_seq_out;
    t_seq        r_acked;
    logic        r_res_valid;
    t_res        r_res;

    t_seq        oldest;
    t_seq        count_raw;
    t_seq        count;
    t_seq        timed_ofs;
    logic        timed_hit;
    logic        can_send;
    logic [20:0] setup_prod;
    t_time       setup_srt;
    logic [31:0] rtt;
    logic [31:0] srt_ext;
    logic [31:0] err;
    logic [34:0] srt_sum;
    logic [34:0] mdev_sum;
    t_time       srt_new;
    t_time       mdev_new;
    t_seq        win;
    t_time       quotient;
    logic        div_done;
    logic [24:0] inc_sum;
    t_time       mdev_grown;
    logic [26:0] rto_sum;
    t_time       rto;

    // acknowledgement arithmetic, all modulo 8
    always_comb begin
        oldest    = r_send_seq - r_outst;
        count_raw = r_evt.ack_number - oldest;
        count     = (count_raw > r_outst) ? r_outst : count_raw;
        timed_ofs = r_timed_seq - oldest;
        timed_hit = r_timing && (timed_ofs < count);
        can_send  = (r_outst < r_cwnd) && (r_outst != MAX_OUTSTANDING);
    end

    // base * (1 + 2*hops) / 2 stays below 2^21, no saturation needed
    assign setup_prod = i_base_timeout * {r_evt.hop_count, 1'b1};
    assign setup_srt  = TIME_BITS'(setup_prod[20:1]);

    // Jacobson update: srt = (7*srt + rtt + 4)/8, mdev = (3*mdev + |err| + 2)/4
    always_comb begin
        rtt      = r_evt.now_ms - r_timed_start;
        srt_ext  = 32'(r_srt);
        err      = (rtt > srt_ext) ? (rtt - srt_ext) : (srt_ext - rtt);
        srt_sum  = 35'({r_srt, 3'b000}) - 35'(r_srt) + 35'(rtt) + 35'd4;
        mdev_sum = 35'({r_mdev, 1'b0}) + 35'(r_mdev) + 35'(err) + 35'd2;
        srt_new  = sat24(35'(srt_sum[34:3]));
        mdev_new = sat24(35'(mdev_sum[34:2]));
    end

    assign win = (r_cwnd == '0) ? SEQ_BITS'(1) : r_cwnd;

    artt_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (r_srt),
        .i_divisor  (win),
        .o_quotient (quotient),
        .o_done     (div_done)
    );

    always_comb begin
        inc_sum    = 25'(quotient) + 25'd2;
        mdev_grown = sat24(35'(r_mdev) + 35'(inc_sum[24:2]));
    end

    // retry timeout: max(500, srt + 4*mdev), saturated
    always_comb begin
        rto_sum = 27'(r_srt) + 27'({r_mdev, 2'b00});
        if (rto_sum < 27'(MIN_RTO)) begin
            rto = TIME_BITS'(MIN_RTO);
        end else begin
            rto = sat24(35'(rto_sum));
        end
    end

    always_comb begin
        o_sts.need_meas = (r_evt.kind == KIND_ACK) && timed_hit
                          && ((timed_ofs != '0) || !r_retx);
        o_sts.need_grow = (r_cwnd < i_max_window);
        o_sts.div_done  = div_done;
        o_sts.out_free  = !r_res_valid || i_res_ready;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_srt         <= '0;
            r_mdev        <= '0;
            r_cwnd        <= SEQ_BITS'(1);
            r_outst       <= '0;
            r_send_seq    <= '0;
            r_timed_seq   <= '0;
            r_timed_start <= '0;
            r_timing      <= 1'b0;
            r_retx        <= 1'b0;
            r_accepted    <= 1'b0;
            r_seq_out     <= '0;
            r_acked       <= '0;
            r_res_valid   <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_accepted <= 1'b0;
                r_seq_out  <= '0;
                r_acked    <= '0;
            end
            if (i_cmd.exec) begin
                unique case (r_evt.kind)
                    KIND_SETUP: begin
                        r_srt  <= setup_srt;
                        r_mdev <= {2'b00, setup_srt[TIME_BITS-1:2]};
                    end
                    KIND_SEND: begin
                        if (can_send) begin
                            r_accepted <= 1'b1;
                            r_seq_out  <= r_send_seq;
                            if (!r_timing) begin
                                r_timed_seq   <= r_send_seq;
                                r_timed_start <= r_evt.now_ms;
                                r_timing      <= 1'b1;
                            end
                            r_outst    <= r_outst + 1'b1;
                            r_send_seq <= r_send_seq + 1'b1;
                        end
                    end
                    KIND_ACK: begin
                        r_acked <= count;
                        r_outst <= r_outst - count;
                        if (timed_hit) r_timing <= 1'b0;
                        if (count != '0) r_retx <= 1'b0;
                    end
                    KIND_REJECT: begin
                        r_cwnd   <= SEQ_BITS'(1);
                        r_timing <= 1'b0;
                    end
                    KIND_RETX: begin
                        r_retx <= 1'b1;
                    end
                    default: begin
                    end
                endcase
            end
            if (i_cmd.meas) begin
                r_srt  <= srt_new;
                r_mdev <= mdev_new;
            end
            if (i_cmd.grow) begin
                r_mdev <= mdev_grown;
                r_cwnd <= r_cwnd + 1'b1;
            end
            if (i_cmd.out_load) begin
                r_res_valid <= 1'b1;
            end else if (i_res_ready) begin
                r_res_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_evt <= i_evt;
        end
        if (i_cmd.out_load) begin
            r_res.accepted         <= r_accepted;
            r_res.sent_sequence    <= r_seq_out;
            r_res.frames_acked     <= r_acked;
            r_res.unacked_count    <= r_outst;
            r_res.window_size      <= r_cwnd;
            r_res.retry_timeout_ms <= rto;
            r_res.all_acked        <= (r_outst == '0);
        end
    end

    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

endmodule

/* hdl/ack_rtt_window_tracker_unit.sv */
// Top level of the ACK/RTT window tracker: APB register file, controller and datapath.
// Depends on artt_pkg, artt_if, artt_ctrl, artt_dp.
//
// One result transfer per event transfer, in order. Each event is executed and its
// result is then loaded into the output register. An acknowledgement that closes a
// timed round trip adds a measurement step, unless the timed frame is the oldest
// while a retransmission is flagged; when it also grows the window, the radix-8
// divider for srt/window (a start step, steps of 3 quotient bits each, a done step)
// and the growth update come before the result loads. The next event transfer can
// follow in the cycle after the result loads; an event is held longer while the
// output register is still full. One event is in process at a time; a new event
// transfer is taken while an earlier result still waits in the output register.
// Registers: max_window at byte 0, base_timeout_ms at byte 4; write only while idle.
module ack_rtt_window_tracker_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    artt_evt_if.sink           i_evt,
    artt_res_if.source         o_res,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import artt_pkg::*;

    logic [2:0]  r_max_window;
    logic [15:0] r_base_timeout;
    t_cmd        cmd;
    t_sts        sts;
    logic        evt_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_window   <= 3'd7;
            r_base_timeout <= 16'd5000;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[2])
                REG_MAX_WINDOW:   r_max_window   <= pwdata[2:0];
                REG_BASE_TIMEOUT: r_base_timeout <= pwdata[15:0];
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_MAX_WINDOW:   prdata = {29'd0, r_max_window};
            REG_BASE_TIMEOUT: prdata = {16'd0, r_base_timeout};
        endcase
    end

    assign pready = 1'b1;

    artt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_evt_valid (i_evt.valid),
        .o_evt_ready (evt_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    artt_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_max_window   (r_max_window),
        .i_base_timeout (r_base_timeout),
        .i_evt          (i_evt.data),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .o_res_valid    (o_res.valid),
        .o_res          (o_res.data),
        .i_res_ready    (o_res.ready)
    );

    assign i_evt.ready = evt_ready;

endmodule
